// ===== rtl/core/psht_pkg.sv =====
// ----------------------------------------------------------------------------
// psht_pkg
// shared types, codes and reset values of the peer slot handshake table
// ----------------------------------------------------------------------------
`default_nettype none

package psht_pkg;

  // default table depth
  localparam int MAX_SLOTS_DEF = 16;

  // payload field widths
  localparam int ADDR_W   = 48;
  localparam int TIME_W   = 32;
  localparam int PTYPE_W  = 2;
  localparam int LIMIT_W  = 5;
  localparam int TMO_W    = 29;
  localparam int THR_W    = TMO_W + 4;
  localparam int OIDX_W   = 4;
  localparam int OCOUNT_W = 5;

  // configuration port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = TMO_W;
  localparam logic [CFG_ADDR_W-1:0] REG_SLOT_LIMIT = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT_MS = 1'd1;

  localparam logic [LIMIT_W-1:0] SLOT_LIMIT_RST = 5'd16;
  localparam logic [TMO_W-1:0]   TIMEOUT_RST    = 29'd10000;

  // input kinds and packet types
  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_TICK   = 1'b1;
  localparam logic [PTYPE_W-1:0] PT_REQUEST = 2'd0;
  localparam logic [PTYPE_W-1:0] PT_ACK     = 2'd1;

  typedef enum logic [1:0] {
    ST_FREE = 2'd0,
    ST_TEMP = 2'd1,
    ST_CONN = 2'd2
  } slot_state_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_ACCEPT  = 3'd1,
    EV_DENY    = 3'd2,
    EV_REFRESH = 3'd3,
    EV_PROMOTE = 3'd4,
    EV_REMOVE  = 3'd5
  } event_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_DECIDE,
    S_SWEEP,
    S_CLOSE
  } fsm_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/psht_ram.sv =====
// ----------------------------------------------------------------------------
// psht_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module psht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/peer_slot_handshake_table_top.sv =====
// ----------------------------------------------------------------------------
// peer_slot_handshake_table_top
// peer slot table with handshake admission, refresh and timeout sweep
// ----------------------------------------------------------------------------
// The table holds MAX_SLOTS peer slots, each free, temporary or connected.
// A packet request looks its address up among the used slots below the
// effective limit min(slot_limit, MAX_SLOTS) and yields exactly one result;
// a tick request sweeps those slots, yields one removal result per freed
// slot in ascending order, then a closing result with last set. The block
// takes one request at a time: a packet compares one slot per cycle against
// the registered read of the address ram, stopping at the first hit, and a
// tick works one slot per cycle through one shared elapsed-time compare
// while the output side does not stall. No clearing pass is needed after
// reset. A finished result waits in the output register while the next
// request is taken.
`default_nettype none

module peer_slot_handshake_table_top
  import psht_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // request stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [79:0]           s_tdata,   // peer_addr[47:0], now_ms[79:48]
  input  wire logic [2:0]            s_tuser,   // kind[0], packet_type[2:1]
  // result stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [15:0]                m_tdata,   // slot_index[3:0], peer_count[8:4]
  output logic [2:0]                 m_tuser,   // event_res[2:0]
  output logic                       m_tlast
);

  // slot index width and a count width that can hold MAX_SLOTS itself
  localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

  // configuration registers
  logic [LIMIT_W-1:0] slot_limit;
  logic [TMO_W-1:0]   timeout_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_limit <= SLOT_LIMIT_RST;
      timeout_ms <= TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SLOT_LIMIT: slot_limit <= cfg_wdata[LIMIT_W-1:0];
        REG_TIMEOUT_MS: timeout_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective limit min(slot_limit, MAX_SLOTS)
  logic [LW-1:0] limit_ext;
  logic [CW-1:0] lim;
  assign limit_ext = LW'(slot_limit);
  assign lim = (limit_ext < LW'(MAX_SLOTS)) ? CW'(limit_ext) : CW'(MAX_SLOTS);

  // slot state held in flops, reset to free
  slot_state_t          slot_status [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] slot_seen;
  logic [CW-1:0]        used_count;

  // latched request
  logic              kind_r;
  logic [ADDR_W-1:0] addr_r;
  logic [PTYPE_W-1:0] ptype_r;
  logic [TIME_W-1:0] now_r;
  logic [THR_W-1:0]  tmo_temp;    // 10 * timeout for temporary slots

  // sequencer
  fsm_state_t    state, state_next;
  logic [CW-1:0] rd_cnt, rd_cnt_next;      // next slot to read
  logic          chk_vld, chk_vld_next;    // a slot's read data is at the ram output
  logic [IW-1:0] chk_idx, chk_idx_next;
  logic          hit, hit_next;
  logic [IW-1:0] hit_idx, hit_idx_next;
  logic          free_ok, free_ok_next;
  logic [IW-1:0] free_idx, free_idx_next;
  logic          stall;

  // slot updates from the sequencer
  logic          st_we;
  logic [IW-1:0] st_widx;
  slot_state_t   st_wval;
  logic          seen_we;
  logic          seen_wval;
  logic [CW-1:0] used_next;
  logic          peer_we;
  logic          heard_we;
  logic [IW-1:0] ram_waddr;
  logic [IW-1:0] ram_raddr;

  // result to be loaded into the output register
  logic          emit;
  event_t        em_event;
  logic [IW-1:0] em_idx;
  logic [CW-1:0] em_count;
  logic          em_last;
  logic          emit_ok;

  // output register
  logic                out_valid;
  event_t              out_event;
  logic [OIDX_W-1:0]   out_idx;
  logic [OCOUNT_W-1:0] out_count;
  logic                out_last;

  // no request is taken while reset is held
  logic accept;
  assign s_tready = (state == S_IDLE) && !rst;
  assign accept   = s_tvalid && s_tready;
  assign emit_ok  = !out_valid || m_tready;

  // peer address and last-heard time live in rams
  logic [ADDR_W-1:0] peer_rd;
  logic [TIME_W-1:0] heard_rd;

  psht_ram #(
    .WIDTH(ADDR_W),
    .DEPTH(MAX_SLOTS),
    .AW   (IW)
  ) u_peer_ram (
    .clk  (clk),
    .we   (peer_we),
    .waddr(ram_waddr),
    .wdata(addr_r),
    .raddr(ram_raddr),
    .rdata(peer_rd)
  );

  psht_ram #(
    .WIDTH(TIME_W),
    .DEPTH(MAX_SLOTS),
    .AW   (IW)
  ) u_heard_ram (
    .clk  (clk),
    .we   (heard_we),
    .waddr(ram_waddr),
    .wdata(now_r),
    .raddr(ram_raddr),
    .rdata(heard_rd)
  );

  // shared elapsed-time compare for the sweep
  slot_state_t      chk_state;
  logic [TIME_W-1:0] elapsed;
  logic [THR_W-1:0] thr;
  logic             expired;
  logic             drop;
  logic             addr_match;
  logic             issue_ok;

  assign chk_state  = slot_status[chk_idx];
  assign elapsed    = now_r - heard_rd;
  assign thr        = (chk_state == ST_TEMP) ? tmo_temp : THR_W'(timeout_ms);
  assign expired    = THR_W'(elapsed) >= thr;
  assign addr_match = (chk_state != ST_FREE) && (peer_rd == addr_r);
  assign issue_ok   = rd_cnt < lim;

  always_comb begin
    case (chk_state)
      ST_TEMP: drop = expired;
      ST_CONN: drop = expired && slot_seen[chk_idx];
      default: drop = 1'b0;
    endcase
  end

  // hold the read address on the stalled slot so its data stays put
  assign ram_raddr = stall ? chk_idx : IW'(rd_cnt);

  always_comb begin
    state_next    = state;
    rd_cnt_next   = rd_cnt;
    chk_vld_next  = chk_vld;
    chk_idx_next  = chk_idx;
    hit_next      = hit;
    hit_idx_next  = hit_idx;
    free_ok_next  = free_ok;
    free_idx_next = free_idx;
    stall         = 1'b0;
    st_we         = 1'b0;
    st_widx       = chk_idx;
    st_wval       = ST_FREE;
    seen_we       = 1'b0;
    seen_wval     = 1'b0;
    used_next     = used_count;
    peer_we       = 1'b0;
    heard_we      = 1'b0;
    ram_waddr     = hit_idx;
    emit          = 1'b0;
    em_event      = EV_NONE;
    em_idx        = '0;
    em_count      = used_count;
    em_last       = 1'b1;

    case (state)
      S_IDLE: begin
        rd_cnt_next  = '0;
        chk_vld_next = 1'b0;
        hit_next     = 1'b0;
        free_ok_next = 1'b0;
        if (accept) begin
          state_next = (s_tuser[0] == KIND_TICK) ? S_SWEEP : S_LOOK;
        end
      end

      S_LOOK: begin
        if (chk_vld && addr_match) begin
          hit_next     = 1'b1;
          hit_idx_next = chk_idx;
          chk_vld_next = 1'b0;
          state_next   = S_DECIDE;
        end else begin
          // remember the first free slot on the way for a possible admission
          if (chk_vld && chk_state == ST_FREE && !free_ok) begin
            free_ok_next  = 1'b1;
            free_idx_next = chk_idx;
          end
          chk_vld_next = issue_ok;
          chk_idx_next = IW'(rd_cnt);
          if (issue_ok) begin
            rd_cnt_next = rd_cnt + CW'(1);
          end else if (!chk_vld) begin
            state_next = S_DECIDE;
          end
        end
      end

      S_DECIDE: begin
        if (emit_ok) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          if (hit) begin
            // known peer: refresh time and seen flag, ack promotes
            heard_we  = 1'b1;
            seen_we   = 1'b1;
            seen_wval = 1'b1;
            st_widx   = hit_idx;
            em_idx    = hit_idx;
            if (ptype_r == PT_ACK) begin
              st_we    = 1'b1;
              st_wval  = ST_CONN;
              em_event = EV_PROMOTE;
            end else begin
              em_event = EV_REFRESH;
            end
          end else if (ptype_r != PT_REQUEST) begin
            em_event = EV_NONE;
          end else if (used_count < lim && free_ok) begin
            // admit the new peer as temporary in the first free slot
            ram_waddr = free_idx;
            peer_we   = 1'b1;
            heard_we  = 1'b1;
            st_we     = 1'b1;
            st_widx   = free_idx;
            st_wval   = ST_TEMP;
            seen_we   = 1'b1;
            seen_wval = 1'b0;
            used_next = used_count + CW'(1);
            em_event  = EV_ACCEPT;
            em_idx    = free_idx;
            em_count  = used_next;
          end else begin
            em_event = EV_DENY;
          end
        end
      end

      S_SWEEP: begin
        if (chk_vld && drop) begin
          if (emit_ok) begin
            emit     = 1'b1;
            st_we    = 1'b1;
            st_widx  = chk_idx;
            st_wval  = ST_FREE;
            seen_we  = 1'b1;
            seen_wval = 1'b0;
            if (used_count != '0) begin
              used_next = used_count - CW'(1);
            end
            em_event = EV_REMOVE;
            em_idx   = chk_idx;
            em_count = used_next;
            em_last  = 1'b0;
          end else begin
            stall = 1'b1;
          end
        end
        if (!stall) begin
          chk_vld_next = issue_ok;
          chk_idx_next = IW'(rd_cnt);
          if (issue_ok) begin
            rd_cnt_next = rd_cnt + CW'(1);
          end else if (!chk_vld) begin
            state_next = S_CLOSE;
          end
        end
      end

      S_CLOSE: begin
        if (emit_ok) begin
          emit       = 1'b1;
          em_event   = EV_NONE;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rd_cnt     <= '0;
      chk_vld    <= 1'b0;
      hit        <= 1'b0;
      free_ok    <= 1'b0;
      used_count <= '0;
      slot_seen  <= '0;
      out_valid  <= 1'b0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        slot_status[i] <= ST_FREE;
      end
    end else begin
      state      <= state_next;
      rd_cnt     <= rd_cnt_next;
      chk_vld    <= chk_vld_next;
      hit        <= hit_next;
      free_ok    <= free_ok_next;
      used_count <= used_next;
      if (st_we) begin
        slot_status[st_widx] <= st_wval;
      end
      if (seen_we) begin
        slot_seen[st_widx] <= seen_wval;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    chk_idx  <= chk_idx_next;
    hit_idx  <= hit_idx_next;
    free_idx <= free_idx_next;
    if (accept) begin
      kind_r   <= s_tuser[0];
      ptype_r  <= s_tuser[2:1];
      addr_r   <= s_tdata[ADDR_W-1:0];
      now_r    <= s_tdata[ADDR_W+TIME_W-1:ADDR_W];
      tmo_temp <= (THR_W'(timeout_ms) << 3) + (THR_W'(timeout_ms) << 1);
    end
    if (emit) begin
      out_event <= em_event;
      out_idx   <= OIDX_W'(em_idx);
      out_count <= OCOUNT_W'(em_count);
      out_last  <= em_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_event;
  assign m_tdata  = {7'd0, out_count, out_idx};
  assign m_tlast  = out_last;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  logic [MAX_SLOTS-1:0] busy_vec;

  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      busy_vec[i] = (slot_status[i] != ST_FREE);
    end
  end

  // the used count tracks the slots that are not free
  a_used_matches_slots: assert property (@(posedge clk) disable iff (rst)
    used_count == CW'($countones(busy_vec)))
    else $error("used count out of step with slot states");

  a_used_bounded: assert property (@(posedge clk) disable iff (rst)
    used_count <= CW'(MAX_SLOTS))
    else $error("used count above table depth");

  // only sweep removals come out without last
  a_open_is_remove: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tuser == EV_REMOVE)
    else $error("non-final result that is not a removal");

  // a taken request leaves the sequencer busy with its kind latched
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready && (kind_r == $past(s_tuser[0])))
    else $error("request taken while the sequencer is busy");

endmodule

`default_nettype wire

// ===== dv/peer_slot_handshake_table_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// peer_slot_handshake_table_top_test
// self-checking bench for the peer slot table: admission, refresh, sweep
// ----------------------------------------------------------------------------
// A directed table covers the field extremes, every packet type, the zero and
// lowered slot limit, the zero timeout and the time wrap. Random phases then
// replay address pools through several register settings. Every result is
// matched field by field against a spelled-out answer or an in-bench model of the slot table.

module peer_slot_handshake_table_top_test;
  import psht_pkg::*;

  // packet types with no name in the package
  localparam logic [PTYPE_W-1:0] PT_OTHER = 2'd2;
  localparam logic [PTYPE_W-1:0] PT_SPARE = 2'd3;
  localparam logic [47:0] ADDR_ONES = 48'hFFFF_FFFF_FFFF;
  localparam logic [TMO_W-1:0] TMO_MAX = 29'h1FFF_FFFF;
  localparam int NUM_PHASES = 9;
  localparam int PHASE_ITEMS = 41;
  localparam int POOL_SIZE = 20;

  typedef enum logic [1:0] {
    OP_PACKET,
    OP_TICK,
    OP_SET_LIMIT,
    OP_SET_TIMEOUT
  } plan_op_t;

  // one row of stimulus; has_answer marks a row whose result is spelled out
  typedef struct packed {
    plan_op_t          op;
    logic [47:0]       addr;
    logic [1:0]        ptype;
    logic [31:0]       now;
    logic [TMO_W-1:0]  value;
    logic              has_answer;
    event_t            ev;
    logic [3:0]        idx;
    logic [4:0]        cnt;
  } plan_row_t;

  typedef struct packed {
    event_t      ev;
    logic [3:0]  idx;
    logic [4:0]  cnt;
    logic        is_last;
  } table_event_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [79:0]           s_tdata;   // peer_addr[47:0], now_ms[79:48]
  logic [2:0]            s_tuser;   // kind[0], packet_type[2:1]
  logic                  m_tvalid;
  logic                  m_tready;
  logic [15:0]           m_tdata;   // slot_index[3:0], peer_count[8:4]
  logic [2:0]            m_tuser;   // event_res[2:0]
  logic                  m_tlast;

  peer_slot_handshake_table_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // bench copy of the slot table and its registers
  slot_state_t      slot_state [MAX_SLOTS_DEF];
  logic [47:0]      slot_addr  [MAX_SLOTS_DEF];
  logic [31:0]      slot_heard [MAX_SLOTS_DEF];
  bit               slot_seen  [MAX_SLOTS_DEF];
  int               peers_held;
  logic [LIMIT_W-1:0] limit_reg;
  logic [TMO_W-1:0]   timeout_reg;

  table_event_t pending_events[$];   // results still owed by the block
  table_event_t step_events[$];      // results of the request just taken
  plan_row_t    plan[$];
  logic [47:0]  peer_pool[POOL_SIZE];

  int mismatches;
  int send_idle_pct;
  int recv_idle_pct;
  table_event_t seen_event;
  table_event_t owed_event;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // generous cap on the whole run
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // works out the results of one request and updates the bench table
  task automatic apply_table_request(input logic kind, input logic [47:0] addr,
                                     input logic [1:0] ptype, input logic [31:0] now);
    int lim;
    int hit;
    int slot;
    logic [31:0] quiet;
    logic [63:0] temp_span;
    bit drop;
    lim = (limit_reg < MAX_SLOTS_DEF) ? int'(limit_reg) : MAX_SLOTS_DEF;
    if (kind == KIND_PACKET) begin
      hit = -1;
      // free slots never match, used slots at or above the limit are hidden
      for (int i = 0; i < lim; i++)
        if (hit < 0 && slot_state[i] != ST_FREE && slot_addr[i] == addr) hit = i;
      if (hit >= 0) begin
        slot_heard[hit] = now;
        slot_seen[hit] = 1'b1;
        if (ptype == PT_ACK) begin
          slot_state[hit] = ST_CONN;
          step_events.push_back('{EV_PROMOTE, 4'(hit), 5'(peers_held), 1'b1});
        end else begin
          step_events.push_back('{EV_REFRESH, 4'(hit), 5'(peers_held), 1'b1});
        end
      end else if (ptype != PT_REQUEST) begin
        step_events.push_back('{EV_NONE, 4'd0, 5'(peers_held), 1'b1});
      end else begin
        slot = -1;
        if (peers_held < lim)
          for (int i = 0; i < lim; i++)
            if (slot < 0 && slot_state[i] == ST_FREE) slot = i;
        if (slot >= 0) begin
          slot_state[slot] = ST_TEMP;
          slot_addr[slot] = addr;
          slot_heard[slot] = now;
          slot_seen[slot] = 1'b0;
          peers_held++;
          step_events.push_back('{EV_ACCEPT, 4'(slot), 5'(peers_held), 1'b1});
        end else begin
          step_events.push_back('{EV_DENY, 4'd0, 5'(peers_held), 1'b1});
        end
      end
    end else begin
      // temporary slots get ten timeouts, which may exceed the 32-bit span
      temp_span = 64'(timeout_reg) * 64'd10;
      for (int i = 0; i < lim; i++) begin
        if (slot_state[i] != ST_FREE) begin
          quiet = now - slot_heard[i];
          if (slot_state[i] == ST_TEMP) drop = (64'(quiet) >= temp_span);
          else drop = (quiet >= 32'(timeout_reg)) && slot_seen[i];
          if (drop) begin
            slot_state[i] = ST_FREE;
            slot_seen[i] = 1'b0;
            if (peers_held > 0) peers_held--;
            step_events.push_back('{EV_REMOVE, 4'(i), 5'(peers_held), 1'b0});
          end
        end
      end
      step_events.push_back('{EV_NONE, 4'd0, 5'(peers_held), 1'b1});
    end
  endtask

  // offers one request, waits for its handshake, then books its results
  task automatic send_request(input plan_row_t r);
    logic kind;
    kind = (r.op == OP_TICK) ? KIND_TICK : KIND_PACKET;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {r.now, r.addr};
    s_tuser  <= {r.ptype, kind};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    apply_table_request(kind, r.addr, r.ptype, r.now);
    if (r.has_answer) pending_events.push_back('{r.ev, r.idx, r.cnt, 1'b1});
    else foreach (step_events[i]) pending_events.push_back(step_events[i]);
    step_events.delete();
  endtask

  // registers change only once the block has handed back everything owed
  task automatic write_register(input logic [CFG_ADDR_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    s_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SLOT_LIMIT) limit_reg = value[LIMIT_W-1:0];
    else timeout_reg = value;
    @(posedge clk);
  endtask

  // result checker and receiver stall
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_event = '{event_t'(m_tuser), m_tdata[3:0], m_tdata[8:4], m_tlast};
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: ev %0d idx %0d count %0d last %0d",
                   seen_event.ev, seen_event.idx, seen_event.cnt, seen_event.is_last);
      end else begin
        owed_event = pending_events.pop_front();
        if (seen_event != owed_event) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected ev %0d idx %0d count %0d last %0d, %s",
                     owed_event.ev, owed_event.idx, owed_event.cnt, owed_event.is_last,
                     $sformatf("got ev %0d idx %0d count %0d last %0d", seen_event.ev,
                               seen_event.idx, seen_event.cnt, seen_event.is_last));
        end
      end
    end
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin : stimulus
    plan_row_t r;
    logic [31:0] now_ms;
    int unsigned step_max;
    int unsigned pick;
    logic [LIMIT_W-1:0] phase_limit;
    logic [TMO_W-1:0] phase_timeout;

    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    m_tready  <= 1'b0;
    mismatches = 0;
    peers_held = 0;
    limit_reg = SLOT_LIMIT_RST;
    timeout_reg = TIMEOUT_RST;
    foreach (slot_state[i]) begin
      slot_state[i] = ST_FREE;
      slot_seen[i] = 1'b0;
      slot_addr[i] = '0;
      slot_heard[i] = '0;
    end

    // directed rows, reset settings: limit 16, timeout 10000
    // empty table tick, unknown non-request
    plan.push_back('{OP_TICK,   48'h0, PT_REQUEST, 32'd0, '0, 1'b1, EV_NONE, 4'd0, 5'd0});
    plan.push_back('{OP_PACKET, 48'h0, PT_OTHER, 32'd0, '0, 1'b1, EV_NONE, 4'd0, 5'd0});
    // admission of the extreme addresses, then every type on a known peer
    plan.push_back('{OP_PACKET, 48'h0, PT_REQUEST, 32'd5, '0, 1'b1, EV_ACCEPT, 4'd0, 5'd1});
    plan.push_back('{OP_PACKET, ADDR_ONES, PT_REQUEST, 32'd10, '0, 1'b1, EV_ACCEPT, 4'd1,
                     5'd2});
    plan.push_back('{OP_PACKET, ADDR_ONES, PT_ACK, 32'd20, '0, 1'b1, EV_PROMOTE, 4'd1, 5'd2});
    plan.push_back('{OP_PACKET, 48'h0, PT_OTHER, 32'd30, '0, 1'b1, EV_REFRESH, 4'd0, 5'd2});
    plan.push_back('{OP_PACKET, 48'h0, PT_SPARE, 32'd40, '0, 1'b1, EV_REFRESH, 4'd0, 5'd2});
    plan.push_back('{OP_PACKET, 48'h0, PT_REQUEST, 32'd50, '0, 1'b1, EV_REFRESH, 4'd0, 5'd2});
    plan.push_back('{OP_PACKET, 48'h0, PT_ACK, 32'd60, '0, 1'b1, EV_PROMOTE, 4'd0, 5'd2});
    // ack on an already connected slot still promotes
    plan.push_back('{OP_PACKET, 48'h0, PT_ACK, 32'd70, '0, 1'b1, EV_PROMOTE, 4'd0, 5'd2});
    plan.push_back('{OP_PACKET, 48'h5555_5555_5555, PT_REQUEST, 32'd100, '0, 1'b1,
                     EV_ACCEPT, 4'd2, 5'd3});
    plan.push_back('{OP_PACKET, 48'hAAAA_AAAA_AAAA, PT_ACK, 32'd110, '0, 1'b1, EV_NONE,
                     4'd0, 5'd3});
    // sweep drops both connected slots, keeps the temporary one
    plan.push_back('{OP_TICK, 48'h0, PT_REQUEST, 32'd10075, '0, 1'b0, EV_NONE, 4'd0, 5'd0});
    // time wraps between request and ack, then the drop lands exactly on the timeout
    plan.push_back('{OP_PACKET, 48'hAAAA_AAAA_AAAA, PT_REQUEST, 32'hFFFF_FF00, '0, 1'b0,
                     EV_NONE, 4'd0, 5'd0});
    plan.push_back('{OP_PACKET, 48'hAAAA_AAAA_AAAA, PT_ACK, 32'h0000_0100, '0, 1'b0,
                     EV_NONE, 4'd0, 5'd0});
    plan.push_back('{OP_TICK, 48'h0, PT_REQUEST, 32'h0000_2700, '0, 1'b0, EV_NONE, 4'd0,
                     5'd0});
    plan.push_back('{OP_TICK, 48'h0, PT_REQUEST, 32'h0000_2810, '0, 1'b0, EV_NONE, 4'd0,
                     5'd0});
    // limit of one: table counts as full, slot 2 is hidden from lookup
    plan.push_back('{OP_SET_LIMIT, 48'h0, PT_REQUEST, 32'd0, 29'd1, 1'b0, EV_NONE, 4'd0,
                     5'd0});
    plan.push_back('{OP_PACKET, ADDR_ONES, PT_REQUEST, 32'd20000, '0, 1'b1, EV_DENY, 4'd0,
                     5'd1});
    plan.push_back('{OP_PACKET, 48'h5555_5555_5555, PT_OTHER, 32'd20010, '0, 1'b1, EV_NONE,
                     4'd0, 5'd1});
    // zero limit: nothing looked up or swept
    plan.push_back('{OP_SET_LIMIT, 48'h0, PT_REQUEST, 32'd0, 29'd0, 1'b0, EV_NONE, 4'd0,
                     5'd0});
    plan.push_back('{OP_PACKET, ADDR_ONES, PT_REQUEST, 32'd20020, '0, 1'b1, EV_DENY, 4'd0,
                     5'd1});
    plan.push_back('{OP_TICK, ADDR_ONES, PT_SPARE, 32'hFFFF_FFFF, '0, 1'b1, EV_NONE, 4'd0,
                     5'd1});
    // oversized limit and zero timeout: everything pending goes at once
    plan.push_back('{OP_SET_LIMIT, 48'h0, PT_REQUEST, 32'd0, 29'd31, 1'b0, EV_NONE, 4'd0,
                     5'd0});
    plan.push_back('{OP_SET_TIMEOUT, 48'h0, PT_REQUEST, 32'd0, 29'd0, 1'b0, EV_NONE, 4'd0,
                     5'd0});
    plan.push_back('{OP_TICK, 48'h0, PT_REQUEST, 32'd100, '0, 1'b0, EV_NONE, 4'd0, 5'd0});
    plan.push_back('{OP_SET_TIMEOUT, 48'h0, PT_REQUEST, 32'd0, TMO_MAX, 1'b0, EV_NONE,
                     4'd0, 5'd0});

    send_idle_pct = 12;
    recv_idle_pct = 75;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      case (plan[i].op)
        OP_SET_LIMIT:   write_register(REG_SLOT_LIMIT, plan[i].value);
        OP_SET_TIMEOUT: write_register(REG_TIMEOUT_MS, plan[i].value);
        default:        send_request(plan[i]);
      endcase
    end

    // random phases: a small address pool keeps peers coming back
    peer_pool[0] = 48'h0;
    peer_pool[1] = ADDR_ONES;
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p / 3)
        0: begin
          send_idle_pct = 12;
          recv_idle_pct = 75;
        end
        1: begin
          send_idle_pct = 75;
          recv_idle_pct = 12;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (p)
        0: begin phase_limit = 5'd16; phase_timeout = 29'd40; end
        1: begin phase_limit = 5'd3;  phase_timeout = 29'd25; end
        2: begin phase_limit = 5'd0;  phase_timeout = 29'd10; end
        3: begin phase_limit = 5'd31; phase_timeout = 29'd1;  end
        4: begin phase_limit = 5'd1;  phase_timeout = 29'd0;  end
        5: begin phase_limit = 5'd8;  phase_timeout = TMO_MAX; end
        6: begin phase_limit = 5'd16; phase_timeout = 29'd60; end
        7: begin
          phase_limit = 5'($urandom_range(31));
          phase_timeout = 29'($urandom_range(200));
        end
        default: begin phase_limit = 5'd5; phase_timeout = 29'd30; end
      endcase
      write_register(REG_SLOT_LIMIT, CFG_DATA_W'(phase_limit));
      write_register(REG_TIMEOUT_MS, phase_timeout);
      // swap out about half the pool so old peers linger alongside new ones
      for (int k = 2; k < POOL_SIZE; k++)
        if (p == 0 || $urandom_range(1) == 1) peer_pool[k] = 48'({$urandom, $urandom});
      now_ms = $urandom;
      step_max = (timeout_reg < 200) ? 2 * timeout_reg + 5 : 3000;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = '0;
        r.op = ($urandom_range(99) < 15) ? OP_TICK : OP_PACKET;
        r.addr = ($urandom_range(99) < 8) ? 48'({$urandom, $urandom})
                                           : peer_pool[$urandom_range(POOL_SIZE - 1)];
        // mostly request then ack, with refresh traffic and spare types mixed in
        pick = $urandom_range(99);
        if (pick < 40) r.ptype = PT_REQUEST;
        else if (pick < 75) r.ptype = PT_ACK;
        else if (pick < 92) r.ptype = PT_OTHER;
        else r.ptype = PT_SPARE;
        // occasional jump anywhere on the clock, otherwise steady progress
        if ($urandom_range(24) == 0) now_ms = $urandom;
        else now_ms = now_ms + $urandom_range(step_max);
        r.now = now_ms;
        send_request(r);
      end
    end

    s_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    // catch any stray result after the last one owed
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/psht_pkg.sv
rtl/core/psht_ram.sv
rtl/core/peer_slot_handshake_table_top.sv
dv/peer_slot_handshake_table_top_test.sv
